// File: rtl/fprs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprs_pkg
// Shared types and constants of the FIFO resident-set keeper.
// ----------------------------------------------------------------------------
package fprs_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned PAGE_W  = 36;
  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned PERM_W  = 2;

  localparam logic [PERM_W-1:0] PERM_READ       = 2'd1;
  localparam logic [PERM_W-1:0] PERM_READ_WRITE = 2'd3;

  // register index of the resident limit
  localparam logic REG_RESIDENT_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } ctrl_state_e;

  // write port of the page memory
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [PAGE_W-1:0] page;
    logic              dirty;
  } ram_wr_t;

  // one result transaction
  typedef struct packed {
    logic              was_resident;
    logic [PERM_W-1:0] granted_permission;
    logic              evict_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic              evicted_dirty;
  } result_t;

endpackage

// File: rtl/fprs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprs_ram
// Page memory: page number and dirty mark per ring slot, one write port and
// one read port with registered read data.
// ----------------------------------------------------------------------------
module fprs_ram (
  input  logic                              clk_i,
  input  fprs_pkg::ram_wr_t                 wr_i,
  input  logic                              rd_en_i,
  input  logic [fprs_pkg::SLOT_W-1:0]       rd_addr_i,
  output logic [fprs_pkg::PAGE_W-1:0]       rd_page_o,
  output logic                              rd_dirty_o
);

  logic [fprs_pkg::PAGE_W:0] mem_q [fprs_pkg::DEPTH];
  logic [fprs_pkg::PAGE_W:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= {wr_i.page, wr_i.dirty};
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_page_o  = rdata_q[fprs_pkg::PAGE_W:1];
  assign rd_dirty_o = rdata_q[0];

endmodule

// File: rtl/fprs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprs_ctrl
// Fault sequencer: scans the resident ring one memory read per cycle, then
// upgrades a hit or inserts the new page, evicting the oldest one at the limit.
// ----------------------------------------------------------------------------
module fprs_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // fault transactions
  input  logic                              fault_valid_i,
  output logic                              fault_ready_o,
  input  logic [fprs_pkg::PAGE_W-1:0]       fault_page_i,
  // effective resident limit, 1..DEPTH
  input  logic [fprs_pkg::CNT_W-1:0]        limit_i,
  // result toward the output stage
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output fprs_pkg::result_t                 res_o,
  // page memory
  output fprs_pkg::ram_wr_t                 ram_wr_o,
  output logic                              ram_rd_en_o,
  output logic [fprs_pkg::SLOT_W-1:0]       ram_rd_addr_o,
  input  logic [fprs_pkg::PAGE_W-1:0]       ram_rd_page_i,
  input  logic                              ram_rd_dirty_i
);

  fprs_pkg::ctrl_state_e            state_q, state_d;
  logic [fprs_pkg::PAGE_W-1:0]      page_q, page_d;
  logic [fprs_pkg::CNT_W-1:0]       idx_q, idx_d;
  logic                             pend_q, pend_d;
  logic                             pend_first_q, pend_first_d;
  logic [fprs_pkg::SLOT_W-1:0]      pend_slot_q, pend_slot_d;
  logic [fprs_pkg::SLOT_W-1:0]      oldest_q, oldest_d;
  logic [fprs_pkg::CNT_W-1:0]       count_q, count_d;
  logic [fprs_pkg::PAGE_W-1:0]      ev_page_q, ev_page_d;
  logic                             ev_dirty_q, ev_dirty_d;
  fprs_pkg::result_t                res_q, res_d;

  logic                             hit;
  logic                             more;
  logic                             evict;
  logic [fprs_pkg::SLOT_W-1:0]      scan_slot;
  logic [fprs_pkg::SLOT_W-1:0]      tail_slot;

  // scan position and decisions
  assign scan_slot = oldest_q + idx_q[fprs_pkg::SLOT_W-1:0];
  assign tail_slot = oldest_q + count_q[fprs_pkg::SLOT_W-1:0];
  assign hit       = pend_q && (ram_rd_page_i == page_q);
  assign more      = (idx_q < count_q);
  assign evict     = (count_q != '0) && (count_q >= limit_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fprs_pkg::ST_IDLE: begin
        if (fault_valid_i) state_d = fprs_pkg::ST_SCAN;
      end
      fprs_pkg::ST_SCAN: begin
        if (hit || (!pend_q && !more)) state_d = fprs_pkg::ST_RESULT;
      end
      fprs_pkg::ST_RESULT: begin
        if (res_ready_i) state_d = fprs_pkg::ST_IDLE;
      end
      default: state_d = fprs_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    page_d        = page_q;
    idx_d         = idx_q;
    pend_d        = 1'b0;
    pend_first_d  = pend_first_q;
    pend_slot_d   = pend_slot_q;
    oldest_d      = oldest_q;
    count_d       = count_q;
    ev_page_d     = ev_page_q;
    ev_dirty_d    = ev_dirty_q;
    res_d         = res_q;
    ram_wr_o      = '0;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = scan_slot;
    fault_ready_o = (state_q == fprs_pkg::ST_IDLE);
    res_valid_o   = (state_q == fprs_pkg::ST_RESULT);

    unique case (state_q)
      fprs_pkg::ST_IDLE: begin
        if (fault_valid_i) begin
          page_d     = fault_page_i;
          idx_d      = '0;
          ev_page_d  = '0;
          ev_dirty_d = 1'b0;
        end
      end
      fprs_pkg::ST_SCAN: begin
        // the first read of the scan returns the oldest page
        if (pend_q && pend_first_q) begin
          ev_page_d  = ram_rd_page_i;
          ev_dirty_d = ram_rd_dirty_i;
        end
        if (hit) begin
          // write upgrade: mark dirty
          ram_wr_o.en                    = 1'b1;
          ram_wr_o.addr                  = pend_slot_q;
          ram_wr_o.page                  = page_q;
          ram_wr_o.dirty                 = 1'b1;
          res_d.was_resident             = 1'b1;
          res_d.granted_permission       = fprs_pkg::PERM_READ_WRITE;
          res_d.evict_valid              = 1'b0;
          res_d.evicted_page             = '0;
          res_d.evicted_dirty            = 1'b0;
        end else if (more) begin
          // issue the next ring read
          ram_rd_en_o  = 1'b1;
          idx_d        = idx_q + 1'b1;
          pend_d       = 1'b1;
          pend_slot_d  = scan_slot;
          pend_first_d = (idx_q == '0);
        end else if (!pend_q) begin
          // miss: insert at the tail, evicting the oldest if at the limit
          ram_wr_o.en              = 1'b1;
          ram_wr_o.addr            = tail_slot;
          ram_wr_o.page            = page_q;
          ram_wr_o.dirty           = 1'b0;
          res_d.was_resident       = 1'b0;
          res_d.granted_permission = fprs_pkg::PERM_READ;
          res_d.evict_valid        = evict;
          res_d.evicted_page       = evict ? ev_page_q : '0;
          res_d.evicted_dirty      = evict & ev_dirty_q;
          if (evict) begin
            oldest_d = oldest_q + 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      fprs_pkg::ST_RESULT: ;
      default: ;
    endcase
  end

  assign res_o = res_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fprs_pkg::ST_IDLE;
      pend_q   <= 1'b0;
      oldest_q <= '0;
      count_q  <= '0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    idx_q        <= idx_d;
    pend_first_q <= pend_first_d;
    pend_slot_q  <= pend_slot_d;
    ev_page_q    <= ev_page_d;
    ev_dirty_q   <= ev_dirty_d;
    res_q        <= res_d;
  end

endmodule

// File: rtl/fifo_page_fault_resident_set.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_page_fault_resident_set
// FIFO resident-set keeper: write upgrade of resident pages, FIFO eviction
// and insertion of new pages, with an APB limit register.
// ----------------------------------------------------------------------------
// A fault is accepted when the block is idle, and its result is offered once
// the scan ends (a hit ends it early): the resident ring lives in a
// single-port-read page memory that is scanned one slot per cycle, oldest
// first. The result sits in an output register, so the next fault can be
// taken in the same cycle as the result is offered, even while that result
// still waits. The resident limit at byte address 0 keeps the low five bits
// of a write and reads them back; zero acts as one and values above sixteen
// act as sixteen.
module fifo_page_fault_resident_set (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // fault transactions
  input  logic                              fault_valid_i,
  output logic                              fault_ready_o,
  input  logic [fprs_pkg::PAGE_W-1:0]       fault_page_i,
  // result transactions
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output logic                              was_resident_o,
  output logic [fprs_pkg::PERM_W-1:0]       granted_permission_o,
  output logic                              evict_valid_o,
  output logic [fprs_pkg::PAGE_W-1:0]       evicted_page_o,
  output logic                              evicted_dirty_o
);

  logic [fprs_pkg::LIMIT_W-1:0]  limit_q, limit_d;
  logic [fprs_pkg::CNT_W-1:0]    eff_limit;
  logic                          reg_wr;

  logic                          res_valid;
  logic                          res_ready;
  fprs_pkg::result_t             res;
  logic                          out_valid_q, out_valid_d;
  fprs_pkg::result_t             out_q, out_d;

  fprs_pkg::ram_wr_t             ram_wr;
  logic                          ram_rd_en;
  logic [fprs_pkg::SLOT_W-1:0]   ram_rd_addr;
  logic [fprs_pkg::PAGE_W-1:0]   ram_rd_page;
  logic                          ram_rd_dirty;

  // register write and read back
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == fprs_pkg::REG_RESIDENT_LIMIT);
  assign limit_d = reg_wr ? pwdata[fprs_pkg::LIMIT_W-1:0] : limit_q;
  assign prdata = (paddr[2] == fprs_pkg::REG_RESIDENT_LIMIT)
                  ? {{(32-fprs_pkg::LIMIT_W){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= fprs_pkg::LIMIT_W'(1);
    end else begin
      limit_q <= limit_d;
    end
  end

  // clamp the limit to 1..DEPTH
  always_comb begin
    priority if (limit_q == '0) begin
      eff_limit = fprs_pkg::CNT_W'(1);
    end else if (limit_q > fprs_pkg::LIMIT_W'(fprs_pkg::DEPTH)) begin
      eff_limit = fprs_pkg::CNT_W'(fprs_pkg::DEPTH);
    end else begin
      eff_limit = fprs_pkg::CNT_W'(limit_q);
    end
  end

  fprs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fault_valid_i  (fault_valid_i),
    .fault_ready_o  (fault_ready_o),
    .fault_page_i   (fault_page_i),
    .limit_i        (eff_limit),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .ram_wr_o       (ram_wr),
    .ram_rd_en_o    (ram_rd_en),
    .ram_rd_addr_o  (ram_rd_addr),
    .ram_rd_page_i  (ram_rd_page),
    .ram_rd_dirty_i (ram_rd_dirty)
  );

  fprs_ram u_ram (
    .clk_i      (clk_i),
    .wr_i       (ram_wr),
    .rd_en_i    (ram_rd_en),
    .rd_addr_i  (ram_rd_addr),
    .rd_page_o  (ram_rd_page),
    .rd_dirty_o (ram_rd_dirty)
  );

  // output register
  assign res_ready = !out_valid_q || res_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o          = out_valid_q;
  assign was_resident_o       = out_q.was_resident;
  assign granted_permission_o = out_q.granted_permission;
  assign evict_valid_o        = out_q.evict_valid;
  assign evicted_page_o       = out_q.evicted_page;
  assign evicted_dirty_o      = out_q.evicted_dirty;

endmodule
